/* src/dqap_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted quad address parser package
// Character codes, field widths and group limits shared by the parser.
// ----------------------------------------------------------------------------
package dqap_pkg;

	// Width of one decimal group value.
	localparam int unsigned PART_W = 10;

	// Character codes.
	localparam logic [7:0] DOT_CHAR   = 8'h2E;
	localparam logic [7:0] DIGIT_ZERO = 8'h30;
	localparam logic [7:0] DIGIT_NINE = 8'h39;

	// Most digits allowed in one group.
	localparam logic [1:0] MAX_DIGITS = 2'd3;

	// Group index of the fourth group, and the mark that it has been closed.
	localparam logic [2:0] FOURTH_GROUP = 3'd3;
	localparam logic [2:0] DONE_INDEX   = 3'd4;

	// Number of groups that are stored before the fourth one.
	localparam int unsigned SAVED_GROUPS = 3;

	typedef logic [PART_W-1:0] part_t;

endpackage

/* src/dotted_quad_address_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dotted quad address parser
// Parses a byte stream of the form a.b.c.d into four decimal group values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one character per beat on char_in, with end_of_string set
//   on the final beat of a string. Output channel: one beat per string,
//   carrying the four group values and parse_ok; on a malformed string all
//   values are zero and parse_ok is low.
//   Throughput is one character per cycle unless the input stage stalls.
//   Each accepted beat is held in an input stage register; the parse state
//   and, for the final character, the result register are then updated by a
//   compare and a multiply-by-ten accumulate. The result shows on the output
//   once the final character has passed the input stage and output registers.
//   When the receiver stalls, the result waits in the output register and
//   characters of the next string keep flowing; only a second final
//   character stops in the input stage until the output register frees.
//   Reset clears the parse state, the input stage and the output valid; the
//   block is ready for a new string right after reset.
// ----------------------------------------------------------------------------
module dotted_quad_address_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 char_in,
	input  logic                       end_of_string,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [dqap_pkg::PART_W-1:0] part_one,
	output logic [dqap_pkg::PART_W-1:0] part_two,
	output logic [dqap_pkg::PART_W-1:0] part_three,
	output logic [dqap_pkg::PART_W-1:0] part_four,
	output logic                       parse_ok
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eos_s1;

	// Parse state.
	logic [2:0]       group_q;
	logic [1:0]       digits_q;
	dqap_pkg::part_t  acc_q;
	dqap_pkg::part_t  saved_q [dqap_pkg::SAVED_GROUPS];
	logic             err_q;

	// Next parse state.
	logic [2:0]       group_n;
	logic [1:0]       digits_n;
	dqap_pkg::part_t  acc_n;
	dqap_pkg::part_t  saved_n [dqap_pkg::SAVED_GROUPS];
	logic             err_n;
	logic             ok_n;
	logic             is_digit;

	// Output register.
	logic             out_valid_q;
	dqap_pkg::part_t  part_one_q;
	dqap_pkg::part_t  part_two_q;
	dqap_pkg::part_t  part_three_q;
	dqap_pkg::part_t  part_four_q;
	logic             parse_ok_q;

	logic advance;
	logic result_load;

	// The input stage moves on unless it holds a final character and the
	// output register still holds an untaken result.
	assign advance     = valid_s1 && (!eos_s1 || !out_valid_q || out_ready);
	assign result_load = advance && eos_s1;
	assign in_ready    = !valid_s1 || advance;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= char_in;
			eos_s1  <= end_of_string;
		end
	end

	// Per-character parse step.
	always_comb begin
		is_digit = char_s1 inside {[dqap_pkg::DIGIT_ZERO:dqap_pkg::DIGIT_NINE]};
		group_n  = group_q;
		digits_n = digits_q;
		acc_n    = acc_q;
		saved_n  = saved_q;
		err_n    = err_q;
		if (!err_q && group_q != dqap_pkg::DONE_INDEX) begin
			if (is_digit) begin
				if (digits_q == dqap_pkg::MAX_DIGITS) begin
					err_n = 1'b1;
				end else begin
					acc_n = {acc_q[dqap_pkg::PART_W-4:0], 3'b000}
						+ {acc_q[dqap_pkg::PART_W-2:0], 1'b0}
						+ {{(dqap_pkg::PART_W-4){1'b0}}, char_s1[3:0]};
					digits_n = digits_q + 2'd1;
				end
			end else if (digits_q == 2'd0) begin
				err_n = 1'b1;
			end else if (group_q != dqap_pkg::FOURTH_GROUP) begin
				if (char_s1 != dqap_pkg::DOT_CHAR) begin
					err_n = 1'b1;
				end else begin
					saved_n[group_q[1:0]] = acc_q;
					group_n  = group_q + 3'd1;
					digits_n = 2'd0;
					acc_n    = '0;
				end
			end else begin
				// Fourth group closed by a non-digit; the rest is ignored.
				group_n = dqap_pkg::DONE_INDEX;
			end
		end
		ok_n = !err_n && (group_n == dqap_pkg::DONE_INDEX
			|| (group_n == dqap_pkg::FOURTH_GROUP && digits_n != 2'd0));
	end

	// Parse state registers; cleared after each final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_q  <= '0;
			digits_q <= '0;
			acc_q    <= '0;
			saved_q  <= '{default: '0};
			err_q    <= 1'b0;
		end else if (advance) begin
			if (eos_s1) begin
				group_q  <= '0;
				digits_q <= '0;
				acc_q    <= '0;
				saved_q  <= '{default: '0};
				err_q    <= 1'b0;
			end else begin
				group_q  <= group_n;
				digits_q <= digits_n;
				acc_q    <= acc_n;
				saved_q  <= saved_n;
				err_q    <= err_n;
			end
		end
	end

	// Output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload; zeroed on a malformed string.
	always_ff @(posedge clk) begin
		if (result_load) begin
			part_one_q   <= ok_n ? saved_n[0] : '0;
			part_two_q   <= ok_n ? saved_n[1] : '0;
			part_three_q <= ok_n ? saved_n[2] : '0;
			part_four_q  <= ok_n ? acc_n : '0;
			parse_ok_q   <= ok_n;
		end
	end

	assign out_valid  = out_valid_q;
	assign part_one   = part_one_q;
	assign part_two   = part_two_q;
	assign part_three = part_three_q;
	assign part_four  = part_four_q;
	assign parse_ok   = parse_ok_q;

`ifndef NO_ASSERTIONS
	// A failed parse never shows group values.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !parse_ok) |-> (part_one == '0 && part_two == '0
			&& part_three == '0 && part_four == '0))
		else $error("failed parse carries nonzero group values");

	// The group index never passes the closed mark.
	a_group_range: assert property (@(posedge clk) disable iff (!arst_n)
		group_q <= dqap_pkg::DONE_INDEX)
		else $error("group index out of range");

	// A closed fourth group always has at least one digit.
	a_done_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(group_q == dqap_pkg::DONE_INDEX) |-> (digits_q != 2'd0))
		else $error("fourth group closed with no digit");

	// The parse state is clear right after a result is loaded.
	a_clear_after: assert property (@(posedge clk) disable iff (!arst_n)
		result_load |=> (group_q == '0 && digits_q == '0 && acc_q == '0 && !err_q))
		else $error("parse state not cleared after final character");

	// A final character waiting in the input stage stalls only on a held result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (eos_s1 && out_valid_q && !out_ready))
		else $error("input stage stalled without a held result");
`endif

endmodule
